@@ sv/fbac_pkg.sv @@
// ----------------------------------------------------------------------------
// fbac_pkg: shared types, constants and helpers of the border color averager
// Holds the field widths, band and register codes, the clamped configuration
// struct and the clamping functions used by the register bank.
// ----------------------------------------------------------------------------
package fbac_pkg;

    localparam int DIM_W  = 13;  // width of a configuration register
    localparam int CNT_W  = 12;  // column and row counters
    localparam int PX_W   = 8;   // one color channel
    localparam int SUM_W  = 32;  // band sum, wraps modulo 2^32
    localparam int AREA_W = 25;  // largest band area is 4096 * 4096
    localparam int TOT_W  = 10;  // sum of four saturated band averages
    localparam int N_CH   = 4;
    localparam int N_BAND = 4;
    localparam int IDX_W  = 4;   // band * 4 + channel

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // Band codes, used to index the band sums.
    localparam logic [1:0] BAND_TOP    = 2'd0;
    localparam logic [1:0] BAND_RIGHT  = 2'd1;
    localparam logic [1:0] BAND_BOTTOM = 2'd2;
    localparam logic [1:0] BAND_LEFT   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_WIDTH     = 3'd0;
    localparam logic [2:0] REG_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_TOP_END   = 3'd2;
    localparam logic [2:0] REG_BOT_START = 3'd3;
    localparam logic [2:0] REG_LEFT_END  = 3'd4;
    localparam logic [2:0] REG_RIGHT_ST  = 3'd5;

    // Configuration after clamping to the usable frame.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] top_end;
        logic [DIM_W-1:0] bot_start;
        logic [DIM_W-1:0] left_end;
        logic [DIM_W-1:0] right_start;
    } t_cfg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_to(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

endpackage

@@ sv/fbac_ifs.sv @@
// ----------------------------------------------------------------------------
// fbac_ifs: stream channels of the border color averager
// Pixel channel into the block and result channel out of it, both with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbac_pix_if;
    logic                      valid;
    logic                      ready;
    logic [fbac_pkg::PX_W-1:0] red;
    logic [fbac_pkg::PX_W-1:0] green;
    logic [fbac_pkg::PX_W-1:0] blue;
    logic [fbac_pkg::PX_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue,
                    output alpha, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, output ready);
endinterface

interface fbac_res_if;
    logic                      valid;
    logic                      ready;
    logic [fbac_pkg::PX_W-1:0] avg_red;
    logic [fbac_pkg::PX_W-1:0] avg_green;
    logic [fbac_pkg::PX_W-1:0] avg_blue;
    logic [fbac_pkg::PX_W-1:0] avg_alpha;

    modport source (output valid, output avg_red, output avg_green,
                    output avg_blue, output avg_alpha, input ready);
    modport sink   (input valid, input avg_red, input avg_green,
                    input avg_blue, input avg_alpha, output ready);
endinterface

@@ sv/fbac_regs.sv @@
// ----------------------------------------------------------------------------
// fbac_regs: configuration register bank
// APB-style slave holding the frame size and band limits, and presenting
// them clamped to the usable frame.
// ----------------------------------------------------------------------------
module fbac_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output fbac_pkg::t_cfg       o_cfg
);

    logic [fbac_pkg::DIM_W-1:0] r_width, r_height, r_top_end;
    logic [fbac_pkg::DIM_W-1:0] r_bot_start, r_left_end, r_right_st;
    logic [fbac_pkg::DIM_W-1:0] rd_val;
    logic [2:0]                 reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 13'd1;
            r_height    <= 13'd1;
            r_top_end   <= '0;
            r_bot_start <= '0;
            r_left_end  <= '0;
            r_right_st  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                fbac_pkg::REG_WIDTH:     r_width     <= pwdata[fbac_pkg::DIM_W-1:0];
                fbac_pkg::REG_HEIGHT:    r_height    <= pwdata[fbac_pkg::DIM_W-1:0];
                fbac_pkg::REG_TOP_END:   r_top_end   <= pwdata[fbac_pkg::DIM_W-1:0];
                fbac_pkg::REG_BOT_START: r_bot_start <= pwdata[fbac_pkg::DIM_W-1:0];
                fbac_pkg::REG_LEFT_END:  r_left_end  <= pwdata[fbac_pkg::DIM_W-1:0];
                fbac_pkg::REG_RIGHT_ST:  r_right_st  <= pwdata[fbac_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fbac_pkg::REG_WIDTH:     rd_val = r_width;
            fbac_pkg::REG_HEIGHT:    rd_val = r_height;
            fbac_pkg::REG_TOP_END:   rd_val = r_top_end;
            fbac_pkg::REG_BOT_START: rd_val = r_bot_start;
            fbac_pkg::REG_LEFT_END:  rd_val = r_left_end;
            fbac_pkg::REG_RIGHT_ST:  rd_val = r_right_st;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata = {{(32-fbac_pkg::DIM_W){1'b0}}, rd_val};

    // Band limits never reach past the clamped frame.
    always_comb begin
        o_cfg.width       = fbac_pkg::clamp_dim(r_width);
        o_cfg.height      = fbac_pkg::clamp_dim(r_height);
        o_cfg.top_end     = fbac_pkg::clamp_to(r_top_end, o_cfg.height);
        o_cfg.bot_start   = fbac_pkg::clamp_to(r_bot_start, o_cfg.height);
        o_cfg.left_end    = fbac_pkg::clamp_to(r_left_end, o_cfg.width);
        o_cfg.right_start = fbac_pkg::clamp_to(r_right_st, o_cfg.width);
    end

endmodule

@@ sv/fbac_accum.sv @@
// ----------------------------------------------------------------------------
// fbac_accum: raster position tracking and band sum accumulation
// Follows column and row of each transferred pixel and adds it to the sums of
// every border band that holds it.
// ----------------------------------------------------------------------------
module fbac_accum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fbac_pkg::t_cfg              i_cfg,
    input  logic                        i_accept,
    input  logic [fbac_pkg::PX_W-1:0]   i_px [fbac_pkg::N_CH],
    input  logic                        i_clear,
    input  logic [fbac_pkg::IDX_W-1:0]  i_rd_idx,
    output logic [fbac_pkg::SUM_W-1:0]  o_rd_sum,
    output logic                        o_frame_end
);

    logic [fbac_pkg::CNT_W-1:0] r_col, r_row;
    logic [fbac_pkg::SUM_W-1:0] r_sums [fbac_pkg::N_BAND*fbac_pkg::N_CH];
    logic [fbac_pkg::DIM_W-1:0] col_ext, row_ext;
    logic                       last_col, last_row;
    logic [fbac_pkg::N_BAND-1:0] member;

    assign col_ext  = {1'b0, r_col};
    assign row_ext  = {1'b0, r_row};
    assign last_col = (col_ext + 13'd1) >= i_cfg.width;
    assign last_row = (row_ext + 13'd1) >= i_cfg.height;
    assign o_frame_end = last_col && last_row;

    always_comb begin
        member[fbac_pkg::BAND_TOP]    = row_ext <  i_cfg.top_end;
        member[fbac_pkg::BAND_RIGHT]  = col_ext >= i_cfg.right_start;
        member[fbac_pkg::BAND_BOTTOM] = row_ext >= i_cfg.bot_start;
        member[fbac_pkg::BAND_LEFT]   = col_ext <  i_cfg.left_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < fbac_pkg::N_BAND; b++) begin
            for (int c = 0; c < fbac_pkg::N_CH; c++) begin
                if (!i_rst_n || i_clear) begin
                    r_sums[b*fbac_pkg::N_CH + c] <= '0;
                end else if (i_accept && member[b]) begin
                    r_sums[b*fbac_pkg::N_CH + c] <= r_sums[b*fbac_pkg::N_CH + c]
                        + {{(fbac_pkg::SUM_W-fbac_pkg::PX_W){1'b0}}, i_px[c]};
                end
            end
        end
    end

    assign o_rd_sum = r_sums[i_rd_idx];

endmodule

@@ sv/fbac_div.sv @@
// ----------------------------------------------------------------------------
// fbac_div: restoring divider, one quotient bit per cycle
// Divides a 32-bit band sum by a band area; o_done pulses for
// one cycle with the quotient valid on o_quot.
// ----------------------------------------------------------------------------
module fbac_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fbac_pkg::SUM_W-1:0]   i_dividend,
    input  logic [fbac_pkg::AREA_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [fbac_pkg::SUM_W-1:0]   o_quot
);

    logic                        r_busy, r_done;
    logic [4:0]                  r_cnt;
    logic [fbac_pkg::AREA_W-1:0] r_rem;
    logic [fbac_pkg::SUM_W-1:0]  r_quo;
    logic [fbac_pkg::AREA_W:0]   shifted, diff;
    logic                        ge;

    // Remainder stays below the divisor, so one extra bit covers the shift.
    assign shifted = {r_rem, r_quo[fbac_pkg::SUM_W-1]};
    assign diff    = shifted - {1'b0, i_divisor};
    assign ge      = shifted >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[fbac_pkg::AREA_W-1:0] : shifted[fbac_pkg::AREA_W-1:0];
            r_quo <= {r_quo[fbac_pkg::SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ sv/frame_border_average_color.sv @@
// ----------------------------------------------------------------------------
// frame_border_average_color: average color of a frame's border bands
// Accumulates RGBA pixels per border band and, at the end of each frame,
// reports the mean of the four band averages for every channel.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive in raster order on i_pix, one transfer per cycle while the
// block accumulates; the block tracks column and row itself from the frame
// size registers. Software sets the frame size and the four band limits
// through the APB-style port while no frame is in flight.
// When the last pixel of a frame is transferred, ready drops and a sequencer
// works through the 16 band sums with one shared restoring divider: per band
// it forms the band area on a single multiplier, then for each channel it
// starts a division, takes 32 quotient bits and accumulates. The result is
// loaded into the output register after the last band, and the sums are
// cleared in that same cycle, so the next frame's first pixel can transfer
// in the following cycle. Throughput is one pixel per cycle within a frame;
// no pixels are taken while the sequencer works through the sums.
// The result waits in an output register: a stalled receiver does not stop
// the next frame from accumulating; only a second finished frame waits until
// the earlier result has been taken.
// Reset clears counters, sums, the sequencer and the output valid flag, and
// sets the width and height registers to 1 and the band limits to 0.
// ----------------------------------------------------------------------------
module frame_border_average_color (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fbac_pix_if.sink          i_pix,
    fbac_res_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Sequencer states: accumulate pixels, form a band area, start a
    // division, wait for it, and hand the result to the output register.
    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,
        S_AREA  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    fbac_pkg::t_cfg cfg;

    logic [1:0]                    r_band, n_band;
    logic [1:0]                    r_ch, n_ch;
    logic [fbac_pkg::AREA_W-1:0]   r_area, n_area;
    logic [fbac_pkg::TOT_W-1:0]    r_total [fbac_pkg::N_CH];
    logic [fbac_pkg::TOT_W-1:0]    n_total [fbac_pkg::N_CH];
    logic                          r_out_valid, n_out_valid;
    logic [fbac_pkg::PX_W-1:0]     r_out [fbac_pkg::N_CH];
    logic [fbac_pkg::PX_W-1:0]     n_out [fbac_pkg::N_CH];

    logic                          accept, frame_end, sum_clear, div_start, div_done;
    logic [fbac_pkg::PX_W-1:0]     px [fbac_pkg::N_CH];
    logic [fbac_pkg::SUM_W-1:0]    rd_sum, quot;
    logic [fbac_pkg::DIM_W-1:0]    mul_a, mul_b;
    logic [2*fbac_pkg::DIM_W-1:0]  prod;
    logic [fbac_pkg::PX_W-1:0]     band_avg;

    fbac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pixel port is open only while accumulating.
    assign i_pix.ready = (r_state == S_ACC);
    assign accept      = i_pix.valid && i_pix.ready;

    assign px[0] = i_pix.red;
    assign px[1] = i_pix.green;
    assign px[2] = i_pix.blue;
    assign px[3] = i_pix.alpha;

    fbac_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_px        (px),
        .i_clear     (sum_clear),
        .i_rd_idx    ({r_band, r_ch}),
        .o_rd_sum    (rd_sum),
        .o_frame_end (frame_end)
    );

    fbac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_sum),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Band area operands; the limits are already clamped to the frame, so
    // the differences never wrap.
    always_comb begin
        case (r_band)
            fbac_pkg::BAND_TOP: begin
                mul_a = cfg.top_end;
                mul_b = cfg.width;
            end
            fbac_pkg::BAND_RIGHT: begin
                mul_a = cfg.height;
                mul_b = cfg.width - cfg.right_start;
            end
            fbac_pkg::BAND_BOTTOM: begin
                mul_a = cfg.height - cfg.bot_start;
                mul_b = cfg.width;
            end
            default: begin
                mul_a = cfg.height;
                mul_b = cfg.left_end;
            end
        endcase
    end

    assign prod = {{fbac_pkg::DIM_W{1'b0}}, mul_a} * {{fbac_pkg::DIM_W{1'b0}}, mul_b};

    // A band average above 255 can only follow a mid-frame change; it
    // saturates.
    assign band_avg = (|quot[fbac_pkg::SUM_W-1:fbac_pkg::PX_W]) ? 8'hFF
                                                                : quot[fbac_pkg::PX_W-1:0];

    assign div_start = (r_state == S_START);

    always_comb begin
        n_state     = r_state;
        n_band      = r_band;
        n_ch        = r_ch;
        n_area      = r_area;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        sum_clear   = 1'b0;

        // A waiting result leaves once the receiver takes it.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_ACC: begin
                if (accept && frame_end) begin
                    n_band  = fbac_pkg::BAND_TOP;
                    n_state = S_AREA;
                end
            end
            S_AREA: begin
                // An empty band divides by one, which yields zero.
                n_area  = (prod[fbac_pkg::AREA_W-1:0] == '0)
                          ? {{(fbac_pkg::AREA_W-1){1'b0}}, 1'b1}
                          : prod[fbac_pkg::AREA_W-1:0];
                n_ch    = 2'd0;
                n_state = S_START;
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_total[r_ch] = r_total[r_ch] + {2'b00, band_avg};
                    if (r_ch == 2'd3) begin
                        if (r_band == fbac_pkg::BAND_LEFT) begin
                            n_state = S_DONE;
                        end else begin
                            n_band  = r_band + 2'd1;
                            n_state = S_AREA;
                        end
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_START;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    for (int c = 0; c < fbac_pkg::N_CH; c++) begin
                        n_out[c]   = r_total[c][fbac_pkg::TOT_W-1:2];
                        n_total[c] = '0;
                    end
                    n_out_valid = 1'b1;
                    sum_clear   = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_band      <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < fbac_pkg::N_CH; c++) begin
                r_total[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_band      <= n_band;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= n_area;
        r_out  <= n_out;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.avg_red   = r_out[0];
    assign o_res.avg_green = r_out[1];
    assign o_res.avg_blue  = r_out[2];
    assign o_res.avg_alpha = r_out[3];

endmodule
